[hdl/hfs_pkg.sv]
// shared types, widths and constants of the heat stencil step block
package hfs_pkg;

    localparam int DATA_W     = 32;
    localparam int SUM_W      = 34;
    localparam int PROD_W     = 50;
    localparam int TOT_W      = 51;
    localparam int ACC_W      = 36;
    localparam int COEF_W     = 18;
    localparam int SIGMA_W    = 15;
    localparam int GRID_W     = 7;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int MIN_SIDE   = 3;
    localparam int Q16_ONE    = 65536;
    localparam int Q16_HALF   = 32768;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA     = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] centre;
        logic signed [DATA_W-1:0] north;
        logic signed [DATA_W-1:0] south;
        logic signed [DATA_W-1:0] east;
        logic signed [DATA_W-1:0] west;
        logic signed [DATA_W-1:0] src;
    } hfs_taps_t;

    typedef struct packed {
        logic top_row;
        logic bottom_row;
        logic left_col;
        logic right_col;
        logic last;
    } hfs_pos_t;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1]);
        if (fits)
            return v[DATA_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

[hdl/hfs_if.sv]
// valid/ready channels for grid cells in and updated cells out
interface hfs_in_if import hfs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [DATA_W-1:0] cell_value;
    logic signed [DATA_W-1:0] source_value;

    modport source (output valid, output kind, output cell_value, output source_value,
                    input ready);
    modport sink (input valid, input kind, input cell_value, input source_value,
                  output ready);
endinterface

interface hfs_out_if import hfs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_value;
    logic                     last_cell;

    modport source (output valid, output new_value, output last_cell, input ready);
    modport sink (input valid, input new_value, input last_cell, output ready);
endinterface

[hdl/hfs_cell.sv]
// one storage cell of a delay line, loads from its neighbor or from the head
module hfs_cell import hfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     shift,
    input  logic                     inject,
    input  logic signed [DATA_W-1:0] head,
    input  logic signed [DATA_W-1:0] prev,
    output logic signed [DATA_W-1:0] q
);

    logic signed [DATA_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= inject ? head : prev;
        end
    end

    assign q = q_reg;

endmodule

[hdl/hfs_delay_line.sv]
// row of cells forming a delay line whose length is set by the injection point
module hfs_delay_line import hfs_pkg::*;
#(
    parameter int MAX_SIDE = 64,
    parameter int POS_W    = $clog2(MAX_SIDE)
)
(
    input  logic                     clk,
    input  logic                     shift,
    input  logic [POS_W-1:0]         inj,
    input  logic signed [DATA_W-1:0] head,
    output logic signed [DATA_W-1:0] tail
);

    logic signed [DATA_W-1:0] q [MAX_SIDE];

    for (genvar j = 0; j < MAX_SIDE; j++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev;
        if (j == 0)
        begin : g_first
            assign prev = head;
        end
        else
        begin : g_rest
            assign prev = q[j-1];
        end

        hfs_cell u_cell (
            .clk    (clk),
            .shift  (shift),
            .inject (inj == POS_W'(j)),
            .head   (head),
            .prev   (prev),
            .q      (q[j])
        );
    end

    assign tail = q[MAX_SIDE-1];

endmodule

[hdl/hfs_update.sv]
// three-stage update pipeline: neighbor sums, weight products, round and saturate
module hfs_update import hfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hfs_taps_t                 taps,
    input  hfs_pos_t                  pos,
    input  logic signed [COEF_W-1:0]  coef,
    input  logic [SIGMA_W-1:0]        sigma,
    hfs_out_if.source                 res
);

    logic                     s1_valid_reg;
    logic                     s1_interior_reg;
    logic                     s1_last_reg;
    logic signed [DATA_W-1:0] s1_centre_reg;
    logic signed [DATA_W-1:0] s1_src_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;
    logic signed [SUM_W-1:0]  s1_edge_reg;

    logic                     s2_valid_reg;
    logic                     s2_interior_reg;
    logic                     s2_last_reg;
    logic signed [DATA_W-1:0] s2_src_reg;
    logic signed [SUM_W-1:0]  s2_edge_reg;
    logic signed [PROD_W-1:0] s2_p1_reg;
    logic signed [PROD_W-1:0] s2_p2_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;

    logic                     out_adv;
    logic                     s2_adv;
    logic                     s1_adv;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  edge_next;
    logic signed [SIGMA_W:0]  sigma_s;
    logic signed [PROD_W-1:0] p1_next;
    logic signed [PROD_W-1:0] p2_next;
    logic signed [TOT_W-1:0]  tot;
    logic signed [ACC_W-1:0]  acc_next;

    assign out_adv  = !out_valid_reg || res.ready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    always_comb
    begin
        sum_next = SUM_W'(taps.north) + SUM_W'(taps.south)
                 + SUM_W'(taps.east) + SUM_W'(taps.west);
        edge_next = SUM_W'(taps.src);
        if (pos.top_row)
            edge_next = edge_next + SUM_W'(taps.south);
        if (pos.bottom_row)
            edge_next = edge_next + SUM_W'(taps.north);
        if (pos.left_col)
            edge_next = edge_next + SUM_W'(taps.east);
        if (pos.right_col)
            edge_next = edge_next + SUM_W'(taps.west);
    end

    assign sigma_s = $signed({1'b0, sigma});
    assign p1_next = coef * s1_centre_reg;
    assign p2_next = sigma_s * s1_sum_reg;

    always_comb
    begin
        tot = TOT_W'(s2_p1_reg) + TOT_W'(s2_p2_reg) + TOT_W'(Q16_HALF);
        if (s2_interior_reg)
            acc_next = ACC_W'(tot >>> FRAC_W) + ACC_W'(s2_src_reg);
        else
            acc_next = ACC_W'(s2_edge_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= in_valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_interior_reg <= !(pos.top_row || pos.bottom_row || pos.left_col || pos.right_col);
            s1_last_reg     <= pos.last;
            s1_centre_reg   <= taps.centre;
            s1_src_reg      <= taps.src;
            s1_sum_reg      <= sum_next;
            s1_edge_reg     <= edge_next;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_interior_reg <= s1_interior_reg;
            s2_last_reg     <= s1_last_reg;
            s2_src_reg      <= s1_src_reg;
            s2_edge_reg     <= s1_edge_reg;
            s2_p1_reg       <= p1_next;
            s2_p2_reg       <= p2_next;
        end
        if (out_adv && s2_valid_reg)
        begin
            out_value_reg <= sat_data(acc_next);
            out_last_reg  <= s2_last_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.new_value = out_value_reg;
    assign res.last_cell = out_last_reg;

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_adv) |=> s2_valid_reg)
        else $error("stage one item lost");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> (out_valid_reg && $stable(out_value_reg)))
        else $error("stalled result changed");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && out_valid_reg && !res.ready) |-> !in_ready)
        else $error("full pipeline took an item");

endmodule

[hdl/heat_ftcs_stencil_step.sv]
// top level: one explicit heat diffusion step over a streamed square grid
// a cell's result is registered through s1, s2 and the output stage after the transfer of the cell N positions later
// throughput: one item per cycle while result_ch is ready; results appear from the (N+1)-th item of a grid on
// window held in three delay lines of MAX_SIDE cells each, injection point set by N
// reset clears handshake state, grid position and config (N = the smaller of 64 and MAX_SIDE, sigma = 0)
// window contents are not reset; writing grid_side restarts the grid position
module heat_ftcs_stencil_step import hfs_pkg::*;
#(
    parameter int MAX_SIDE = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    hfs_in_if.sink                cell_ch,
    hfs_out_if.source             result_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int POS_W   = $clog2(MAX_SIDE);
    localparam int RESET_N = (64 > MAX_SIDE) ? MAX_SIDE : 64;

    logic [POS_W-1:0]         n_m1_reg;
    logic [POS_W-1:0]         inj_reg;
    logic [POS_W-1:0]         inj_a_reg;
    logic [SIGMA_W-1:0]       sigma_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic [SIDE_W-1:0]        count_reg;
    logic [POS_W-1:0]         row_reg;
    logic [POS_W-1:0]         col_reg;
    logic signed [DATA_W-1:0] centre_reg;
    logic signed [DATA_W-1:0] west_reg;

    logic [GRID_W-1:0]        grid_new;
    logic [SIDE_W-1:0]        n_new;
    logic [SIGMA_W-1:0]       sigma_new;
    logic                     xfer;
    logic                     primed;
    logic                     upd_ready;
    logic signed [DATA_W-1:0] south;
    logic signed [DATA_W-1:0] src_in;
    logic signed [DATA_W-1:0] a_tail;
    logic signed [DATA_W-1:0] b_tail;
    logic signed [DATA_W-1:0] s_tail;
    hfs_taps_t                taps;
    hfs_pos_t                 pos;

    assign grid_new  = cfg_data[GRID_W-1:0];
    assign sigma_new = cfg_data[SIGMA_W-1:0];

    always_comb
    begin
        if (grid_new < GRID_W'(MIN_SIDE))
            n_new = SIDE_W'(MIN_SIDE);
        else if (32'(grid_new) > MAX_SIDE)
            n_new = SIDE_W'(MAX_SIDE);
        else
            n_new = SIDE_W'(grid_new);
    end

    assign xfer   = cell_ch.valid && cell_ch.ready;
    assign primed = count_reg > SIDE_W'(n_m1_reg);
    assign south  = cell_ch.kind ? '0 : cell_ch.cell_value;
    assign src_in = cell_ch.kind ? '0 : cell_ch.source_value;

    assign cell_ch.ready = upd_ready;

    assign pos.top_row    = (row_reg == '0);
    assign pos.bottom_row = (row_reg == n_m1_reg);
    assign pos.left_col   = (col_reg == '0);
    assign pos.right_col  = (col_reg == n_m1_reg);
    assign pos.last       = pos.bottom_row && pos.right_col;

    assign taps.centre = centre_reg;
    assign taps.north  = b_tail;
    assign taps.south  = south;
    assign taps.east   = a_tail;
    assign taps.west   = west_reg;
    assign taps.src    = s_tail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_m1_reg  <= POS_W'(RESET_N - 1);
            inj_reg   <= POS_W'(MAX_SIDE - RESET_N);
            inj_a_reg <= POS_W'(MAX_SIDE - RESET_N + 1);
            sigma_reg <= '0;
            coef_reg  <= COEF_W'(Q16_ONE);
            count_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_SIDE:
                begin
                    n_m1_reg  <= POS_W'(n_new - 1'b1);
                    inj_reg   <= POS_W'(SIDE_W'(MAX_SIDE) - n_new);
                    inj_a_reg <= POS_W'(SIDE_W'(MAX_SIDE) - n_new + 1'b1);
                    count_reg <= '0;
                    row_reg   <= '0;
                    col_reg   <= '0;
                end
                REG_SIGMA:
                begin
                    sigma_reg <= sigma_new;
                    coef_reg  <= COEF_W'(Q16_ONE) - $signed({1'b0, sigma_new, 2'b00});
                end
                default:
                begin
                    sigma_reg <= sigma_reg;
                end
            endcase
        end
        else if (xfer)
        begin
            if (!primed)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pos.last)
            begin
                count_reg <= '0;
                row_reg   <= '0;
                col_reg   <= '0;
            end
            else if (pos.right_col)
            begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            centre_reg <= a_tail;
            west_reg   <= centre_reg;
        end
    end

    // delay n-1: east neighbor
    hfs_delay_line #(.MAX_SIDE(MAX_SIDE), .POS_W(POS_W)) u_line_a (
        .clk   (clk),
        .shift (xfer),
        .inj   (inj_a_reg),
        .head  (south),
        .tail  (a_tail)
    );

    // delay 2n: north neighbor
    hfs_delay_line #(.MAX_SIDE(MAX_SIDE), .POS_W(POS_W)) u_line_b (
        .clk   (clk),
        .shift (xfer),
        .inj   (inj_reg),
        .head  (centre_reg),
        .tail  (b_tail)
    );

    // delay n: source of the centre cell
    hfs_delay_line #(.MAX_SIDE(MAX_SIDE), .POS_W(POS_W)) u_line_s (
        .clk   (clk),
        .shift (xfer),
        .inj   (inj_reg),
        .head  (src_in),
        .tail  (s_tail)
    );

    hfs_update u_update (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (xfer && primed),
        .in_ready (upd_ready),
        .taps     (taps),
        .pos      (pos),
        .coef     (coef_reg),
        .sigma    (sigma_reg),
        .res      (result_ch)
    );

    a_grid_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_GRID_SIDE) |=>
            (count_reg == '0 && row_reg == '0 && col_reg == '0))
        else $error("grid write did not restart position");
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_we && xfer && primed && pos.last) |=>
            (count_reg == '0 && row_reg == '0 && col_reg == '0))
        else $error("final cell did not restart grid");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= n_m1_reg && col_reg <= n_m1_reg))
        else $error("grid position out of range");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= SIDE_W'(n_m1_reg) + 1'b1))
        else $error("fill count beyond grid side");

endmodule

[verif/testbench.sv]
// self-checking testbench for the streamed ftcs heat stencil step block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hfs_pkg::*;

    localparam int MAX_SIDE = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 300;
    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct {
        logic signed [DATA_W-1:0] new_value;
        logic                     last_cell;
    } cell_update_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hfs_in_if cell_ch ();
    hfs_out_if result_ch ();

    heat_ftcs_stencil_step #(.MAX_SIDE(MAX_SIDE)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_ch   (cell_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // stencil state mirrored from the block
    logic [GRID_W-1:0]        side_reg = 7'd64;
    logic [SIGMA_W-1:0]       sigma_reg = '0;
    logic signed [DATA_W-1:0] value_hist [0:2*MAX_SIDE];
    logic signed [DATA_W-1:0] source_hist [0:MAX_SIDE];
    int                       cells_in_grid = 0;
    int                       emit_row = 0;
    int                       emit_col = 0;

    cell_update_t pending_updates [$];

    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  grids_done = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;

    initial
    begin
        for (int i = 0; i <= 2 * MAX_SIDE; i++)
            value_hist[i] = '0;
        for (int i = 0; i <= MAX_SIDE; i++)
            source_hist[i] = '0;
    end

    function automatic int effective_side();
        int n;
        n = side_reg;
        if (n < MIN_SIDE)
            n = MIN_SIDE;
        if (n > MAX_SIDE)
            n = MAX_SIDE;
        return n;
    endfunction

    task automatic advance_stencil(input logic flush, input logic signed [DATA_W-1:0] cv,
                                   input logic signed [DATA_W-1:0] sv);
        int n;
        int r;
        int c;
        longint centre;
        longint north;
        longint south;
        longint east;
        longint west;
        longint src;
        longint acc;
        longint coef;
        longint prod;
        cell_update_t upd;
        n = effective_side();
        for (int i = 2 * MAX_SIDE; i > 0; i--)
            value_hist[i] = value_hist[i-1];
        for (int i = MAX_SIDE; i > 0; i--)
            source_hist[i] = source_hist[i-1];
        value_hist[0] = flush ? '0 : cv;
        source_hist[0] = flush ? '0 : sv;
        if (cells_in_grid < n)
        begin
            cells_in_grid++;
            return;
        end
        r = emit_row;
        c = emit_col;
        if (r >= n || c >= n)
        begin
            r = 0;
            c = 0;
        end
        centre = value_hist[n];
        north = value_hist[2*n];
        south = value_hist[0];
        west = value_hist[n+1];
        east = value_hist[n-1];
        src = source_hist[n];
        if (r == 0 || r == n - 1 || c == 0 || c == n - 1)
        begin
            acc = src;
            if (r == 0)
                acc += south;
            if (r == n - 1)
                acc += north;
            if (c == 0)
                acc += east;
            if (c == n - 1)
                acc += west;
        end
        else
        begin
            coef = longint'(Q16_ONE) - 4 * longint'(sigma_reg);
            prod = coef * centre + longint'(sigma_reg) * (north + south + east + west);
            acc = ((prod + longint'(Q16_HALF)) >>> FRAC_W) + src;
        end
        if (acc > SAT_MAX)
            acc = SAT_MAX;
        if (acc < SAT_MIN)
            acc = SAT_MIN;
        upd.new_value = acc[DATA_W-1:0];
        upd.last_cell = (r == n - 1) && (c == n - 1);
        pending_updates = {pending_updates, upd};
        if (upd.last_cell)
        begin
            cells_in_grid = 0;
            emit_row = 0;
            emit_col = 0;
        end
        else
        begin
            cells_in_grid++;
            if (c + 1 >= n)
            begin
                emit_col = 0;
                emit_row = r + 1;
            end
            else
            begin
                emit_col = c + 1;
                emit_row = r;
            end
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            1, 2: return $urandom;
            default: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
        endcase
    endfunction

    task automatic send_cell(input logic flush, input logic signed [DATA_W-1:0] cv,
                             input logic signed [DATA_W-1:0] sv);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_ch.valid <= 1'b1;
        cell_ch.kind <= flush;
        cell_ch.cell_value <= cv;
        cell_ch.source_value <= sv;
        do
            @(posedge clk);
        while (!(cell_ch.valid && cell_ch.ready));
        items_sent++;
        advance_stencil(flush, cv, sv);
    endtask

    task automatic wait_for_drain();
        cell_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_updates.size() != 0);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GRID_SIDE)
        begin
            side_reg = data[GRID_W-1:0];
            cells_in_grid = 0;
            emit_row = 0;
            emit_col = 0;
        end
        else if (idx == REG_SIGMA)
            sigma_reg = data[SIGMA_W-1:0];
    endtask

    // stops after stop_at items when stop_at >= 0; waits for all results at hold_at
    task automatic run_grid(input int noise_pct, input int stop_at, input int hold_at);
        int n;
        int total;
        logic flush;
        n = effective_side();
        total = (stop_at >= 0) ? stop_at : n * n + n;
        for (int p = 0; p < total; p++)
        begin
            if (p == hold_at)
                wait_for_drain();
            flush = (p >= n * n);
            if ($urandom_range(0, 99) < noise_pct)
                flush = !flush;
            send_cell(flush, pick_value(), pick_value());
        end
    endtask

    task automatic test_extreme_values();
        logic signed [DATA_W-1:0] cells [0:8];
        logic signed [DATA_W-1:0] srcs [0:8];
        cells = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX};
        srcs = '{Q_MAX, Q_MIN, '0, '1, Q_MIN, Q_MAX, 32'sd1, '0, Q_MAX};
        set_register(REG_GRID_SIDE, 15'd3);
        set_register(REG_SIGMA, 15'd16384);
        for (int i = 0; i < 9; i++)
            send_cell(1'b0, cells[i], srcs[i]);
        for (int i = 0; i < 3; i++)
            send_cell(1'b1, $urandom, $urandom);
    endtask

    // flush in a data slot reads as zero, data in a flush slot is harmless
    task automatic test_kind_swap();
        set_register(REG_SIGMA, 15'h7FFF);
        for (int i = 0; i < 12; i++)
            send_cell(i == 4 || i == 9 ? 1'b1 : (i == 10 ? 1'b0 : (i >= 9)),
                      pick_value(), pick_value());
    endtask

    task automatic test_side_clamp();
        set_register(REG_GRID_SIDE, {8'hA5, 7'd1});
        set_register(REG_SIGMA, 15'd0);
        run_grid(0, -1, -1);
        set_register(REG_GRID_SIDE, 15'd2);
        set_register(REG_SIGMA, 15'd8192);
        run_grid(0, -1, -1);
    endtask

    task automatic test_restart_mid_grid();
        set_register(REG_GRID_SIDE, 15'd5);
        set_register(REG_SIGMA, 15'($urandom_range(0, 16384)));
        run_grid(0, $urandom_range(3, 28), -1);
        set_register(REG_GRID_SIDE, 15'd4);
        run_grid(0, 9, -1);
        set_register(REG_GRID_SIDE, 15'd4);
        run_grid(0, -1, -1);
    endtask

    task automatic test_drain_pause();
        set_register(REG_GRID_SIDE, 15'd6);
        set_register(REG_SIGMA, 15'($urandom_range(0, 16384)));
        run_grid(0, -1, 20);
    endtask

    task automatic test_largest_grid();
        set_register(REG_GRID_SIDE, 15'd127);
        set_register(REG_SIGMA, 15'($urandom_range(0, 16384)));
        run_grid(0, 200, -1);
    endtask

    task automatic test_random_grids();
        int goal;
        int n;
        int reps;
        int noise;
        int stop_at;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            case ($urandom_range(0, 19))
                0: n = $urandom_range(0, 2);
                1: n = $urandom_range(13, 20);
                2, 3, 4, 5, 6: n = $urandom_range(7, 12);
                default: n = $urandom_range(3, 6);
            endcase
            set_register(REG_GRID_SIDE, 15'(n));
            if ($urandom_range(0, 1))
                set_register(REG_SIGMA, $urandom_range(0, 3) == 0 ?
                             15'($urandom_range(16385, 32767)) : 15'($urandom_range(0, 16384)));
            idle_on = ($urandom_range(0, 3) != 0);
            n = effective_side();
            reps = $urandom_range(1, 2);
            for (int g = 0; g < reps; g++)
            begin
                noise = ($urandom_range(0, 9) == 0) ? 20 : 0;
                stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n * n + n - 1) : -1;
                run_grid(noise, stop_at, ($urandom_range(0, 9) == 0) ?
                         $urandom_range(1, n * n) : -1);
                if (stop_at >= 0)
                    break;
            end
        end
        idle_on = 1'b1;
    endtask

    // result side: random ready stalls before each transfer while idle_on is set
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        cell_update_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (pending_updates.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, new_value %h last_cell %b", $time,
                         result_ch.new_value, result_ch.last_cell);
            end
            else
            begin
                want = pending_updates.pop_front();
                if (result_ch.new_value !== want.new_value)
                begin
                    errors++;
                    $display("%0t: new_value expected %h actual %h", $time,
                             want.new_value, result_ch.new_value);
                end
                if (result_ch.last_cell !== want.last_cell)
                begin
                    errors++;
                    $display("%0t: last_cell expected %b actual %b", $time,
                             want.last_cell, result_ch.last_cell);
                end
                if (want.last_cell)
                    grids_done++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_updates.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        cell_ch.valid <= 1'b0;
        cell_ch.kind <= 1'b0;
        cell_ch.cell_value <= '0;
        cell_ch.source_value <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_values();
        test_kind_swap();
        test_side_clamp();
        test_restart_mid_grid();
        test_drain_pause();
        test_largest_grid();
        test_random_grids();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d cell transfers, %0d results checked, %0d complete grids", items_sent,
                 results_seen, grids_done);
        $display("sides 3 to 64 incl. clamped writes, sigma 0 to 0x7fff, kind swaps, restarts");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
